/* sv/ang_pkg.sv */
// ang_pkg: shared types, constants and codes for the adaptive noise gate controller
// used by ang_ctrl, ang_dp and adaptive_noise_gate_controller
// depends on nothing
package ang_pkg;

   // default block parameters
   localparam int HOLD_FRAMES_DEF        = 15;
   localparam int CALIBRATION_FRAMES_DEF = 200;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPRESSION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VAD_THR     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMFORT_EN  = 2'd2;
   localparam int CSR_DATA_W = 17;

   // q16 gains and coefficients
   localparam logic [16:0] GAIN_ONE     = 17'd65536;
   localparam logic [16:0] RATIO_LIMIT  = 17'd32768;
   localparam logic [16:0] Q_CLAMP_GATE = 17'd19661;
   localparam logic [16:0] Q_SOFT_GATE  = 17'd6554;
   localparam logic [17:0] Q_HYST       = 18'd7864;
   localparam logic [15:0] Q_CLOSE      = 16'd26214;
   localparam logic [15:0] Q_OPEN       = 16'd9830;
   localparam logic [15:0] Q_ALPHA_FAST = 16'd5243;
   localparam logic [15:0] Q_ALPHA_SLOW = 16'd328;

   // q0.24 levels
   localparam logic [23:0] L_MIN_FLOOR = 24'd5033;
   localparam logic [23:0] L_FALLBACK  = 24'd33554;
   localparam logic [23:0] L_RATIO_MIN = 24'd1678;
   localparam logic [23:0] L_CLAMP_MIN = 24'd15099;
   localparam logic [23:0] L_MAX       = 24'd16777215;

   // quotient bits produced by the serial divider after its first compare
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = 4;

   // comfort-noise scale: (n * SCALE_RECIP) >> SCALE_SHIFT is n * 65536 / 6554
   // truncated, exact for n up to 6554
   localparam logic [28:0] SCALE_RECIP = 29'd335523842;
   localparam int          SCALE_SHIFT = 25;

   // register reset values
   localparam logic [16:0] SUPPRESSION_RST = 17'd65536;
   localparam logic [16:0] VAD_THR_RST     = 17'd32768;

   typedef struct packed {
      logic [16:0] vad;
      logic [23:0] frame_rms;
   } req_type;

   typedef struct packed {
      logic [16:0] gate_gain;
      logic [23:0] noise_floor_level;
      logic        speech_detected;
      logic        clamp_enable;
      logic [23:0] clamp_threshold;
      logic [16:0] silence_scale;
   } rsp_type;

   typedef struct packed {
      logic [16:0] suppression_level;
      logic [16:0] vad_threshold;
      logic        comfort_noise_enable;
   } csr_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_in;
      logic floor_mul;
      logic floor_upd;
      logic gate;
      logic div_step;
      logic ratio_take;
      logic gain_mul;
      logic gain_upd;
      logic scale_start;
      logic load_out;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bypass;
      logic need_div;
   } sts_type;

endpackage

/* sv/ang_ctrl.sv */
// ang_ctrl: frame sequencer for the noise gate controller
// drives ang_dp through cmd_type commands and owns both handshakes
// depends on ang_pkg
module ang_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ang_pkg::sts_type sts,
   output ang_pkg::cmd_type cmd
);
   import ang_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FMUL = 4'd1;
   localparam logic [3:0] S_FUPD = 4'd2;
   localparam logic [3:0] S_GATE = 4'd3;
   localparam logic [3:0] S_RDIV = 4'd4;
   localparam logic [3:0] S_RTGT = 4'd5;
   localparam logic [3:0] S_GMUL = 4'd6;
   localparam logic [3:0] S_GUPD = 4'd7;
   localparam logic [3:0] S_SCHK = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd10;

   logic [3:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 last_step;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = sts.bypass ? S_FIN : S_FMUL;
            end
         end
         S_FMUL: begin
            cmd.floor_mul = 1'b1;
            state_in      = S_FUPD;
         end
         S_FUPD: begin
            cmd.floor_upd = 1'b1;
            state_in      = S_GATE;
         end
         S_GATE: begin
            cmd.gate = 1'b1;
            cnt_in   = '0;
            state_in = sts.need_div ? S_RDIV : S_GMUL;
         end
         S_RDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = S_RTGT;
            end
         end
         S_RTGT: begin
            cmd.ratio_take = 1'b1;
            state_in       = S_GMUL;
         end
         S_GMUL: begin
            cmd.gain_mul = 1'b1;
            state_in     = S_GUPD;
         end
         S_GUPD: begin
            cmd.gain_upd = 1'b1;
            state_in     = S_SCHK;
         end
         S_SCHK: begin
            cmd.scale_start = 1'b1;
            state_in        = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output valid: set on load, cleared when taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result is never loaded over one that has not been taken
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // the step counter only runs inside a division
   a_cnt_div: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (state_ff == S_RDIV))
      else $error("divider step count outside a division");

   // an active frame always starts with the floor update
   a_active_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !sts.bypass) |=> (state_ff == S_FMUL))
      else $error("active frame did not start with floor update");

endmodule

/* sv/ang_dp.sv */
// ang_dp: datapath of the noise gate controller: floor and gain state,
// shared approach multiplier, serial divider and result register
// depends on ang_pkg; sequenced by ang_ctrl
module ang_dp #(
   parameter int HOLD_FRAMES        = ang_pkg::HOLD_FRAMES_DEF,
   parameter int CALIBRATION_FRAMES = ang_pkg::CALIBRATION_FRAMES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ang_pkg::req_type req_data,
   input  ang_pkg::csr_type csr,
   input  ang_pkg::cmd_type cmd,
   output ang_pkg::sts_type sts,
   output ang_pkg::rsp_type rsp_data
);
   import ang_pkg::*;

   localparam int HW = $clog2(HOLD_FRAMES + 1);
   localparam int CW = $clog2(CALIBRATION_FRAMES + 1);

   // frame registers
   logic [16:0] vad_ff;
   logic [23:0] rms_ff;
   logic        bypass_ff;
   logic        speech_ff;
   logic        scale_sel_ff;

   // block state
   logic [23:0]   floor_ff;
   logic [CW-1:0] cal_ff;
   logic [HW-1:0] hold_ff;
   logic [16:0]   gain_ff;
   logic [16:0]   target_ff;

   // multiplier and divider registers
   logic [39:0] prod_ff;
   logic        up_ff;
   logic [24:0] rem_ff;
   logic [24:0] den_ff;
   logic [16:0] quo_ff;
   rsp_type     rsp_ff;

   // approach unit signals
   logic [23:0] mul_cur, mul_tgt, mul_d;
   logic [15:0] mul_coef;
   logic        mul_up;
   logic [40:0] step_sum;
   logic [24:0] step;
   logic [24:0] base_cur;
   logic [24:0] appr;

   // gate decision signals
   logic        noise;
   logic [25:0] floor3;
   logic [24:0] gthr;
   logic        by_vad, by_energy, speech;
   logic        rms_lt;
   logic [24:0] diff, den;
   logic        ratio_sat;

   // divider and comfort-noise signals
   logic [25:0] rem_sh;
   logic        step_ge;
   logic        comfort_on;
   logic [16:0] quiet_gap;
   logic [41:0] scale_prod;

   // output signals
   logic [24:0] floor2;
   logic [23:0] clamp_thr;
   logic [23:0] floor_new;

   // shared approach multiplier: floor toward rms, or gain toward target
   always_comb begin
      if (cmd.gain_mul) begin
         mul_cur  = {7'd0, gain_ff};
         mul_tgt  = {7'd0, target_ff};
         mul_coef = (target_ff < gain_ff) ? Q_CLOSE : Q_OPEN;
      end else begin
         mul_cur  = floor_ff;
         mul_tgt  = rms_ff;
         mul_coef = (cal_ff < CW'(CALIBRATION_FRAMES)) ? Q_ALPHA_FAST : Q_ALPHA_SLOW;
      end
      mul_up = (mul_tgt >= mul_cur);
      mul_d  = mul_up ? (mul_tgt - mul_cur) : (mul_cur - mul_tgt);
   end

   // step magnitude rounded up, applied to the value being moved
   assign step_sum = {1'b0, prod_ff} + 41'd65535;
   assign step     = step_sum[40:16];
   assign base_cur = cmd.gain_upd ? {8'd0, gain_ff} : {1'b0, floor_ff};
   assign appr     = up_ff ? (base_cur + step) : (base_cur - step);
   assign floor_new = (floor_ff == '0) ? rms_ff : appr[23:0];

   // noise frame and gate threshold
   assign noise  = ({vad_ff, 1'b0} < {1'b0, csr.vad_threshold});
   assign floor3 = {2'd0, floor_ff} + {1'b0, floor_ff, 1'b0};
   assign gthr   = (floor_ff > L_MIN_FLOOR) ? floor3[25:1] : {1'b0, L_FALLBACK};

   // speech by vad or by energy
   assign by_vad    = (vad_ff >= csr.vad_threshold);
   assign by_energy = (({1'b0, vad_ff} + Q_HYST) >= {1'b0, csr.vad_threshold})
                      && ({2'd0, rms_ff} > {gthr, 1'b0});
   assign speech    = by_vad || by_energy;

   // partial gain ratio operands
   assign rms_lt    = ({1'b0, rms_ff} < gthr);
   assign diff      = {1'b0, rms_ff} - gthr;
   assign den       = (gthr > {1'b0, L_RATIO_MIN}) ? gthr : {1'b0, L_RATIO_MIN};
   assign ratio_sat = (diff >= den);

   // divider step
   assign rem_sh    = {rem_ff, 1'b0};
   assign step_ge   = (rem_sh >= {1'b0, den_ff});

   // comfort-noise scale by reciprocal multiplication
   assign comfort_on = csr.comfort_noise_enable && (gain_ff < Q_SOFT_GATE);
   assign quiet_gap  = Q_SOFT_GATE - gain_ff;
   assign scale_prod = 42'(quiet_gap[12:0] * SCALE_RECIP);

   // status to the controller
   assign sts.bypass   = (csr.suppression_level == '0);
   assign sts.need_div = !speech && (hold_ff == '0) && !rms_lt && !ratio_sat;

   // clamp threshold: twice the floor, limited both ways
   assign floor2    = {floor_ff, 1'b0};
   assign clamp_thr = (floor2 < {1'b0, L_CLAMP_MIN}) ? L_CLAMP_MIN :
                      ((floor2 > {1'b0, L_MAX}) ? L_MAX : floor2[23:0]);

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
         cal_ff   <= '0;
         hold_ff  <= '0;
         gain_ff  <= GAIN_ONE;
      end else begin
         if (cmd.floor_upd && noise) begin
            floor_ff <= (floor_new < L_MIN_FLOOR) ? L_MIN_FLOOR : floor_new;
            if (cal_ff < CW'(CALIBRATION_FRAMES)) begin
               cal_ff <= cal_ff + 1'b1;
            end
         end
         if (cmd.gate) begin
            if (speech) begin
               hold_ff <= HW'(HOLD_FRAMES);
            end else if (hold_ff != '0) begin
               hold_ff <= hold_ff - 1'b1;
            end
         end
         if (cmd.gain_upd) begin
            gain_ff <= (appr > {8'd0, GAIN_ONE}) ? GAIN_ONE : appr[16:0];
         end
      end
   end

   // frame payload, target, multiplier and divider
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         vad_ff       <= req_data.vad;
         rms_ff       <= req_data.frame_rms;
         bypass_ff    <= (csr.suppression_level == '0);
         scale_sel_ff <= 1'b0;
      end
      if (cmd.floor_mul || cmd.gain_mul) begin
         prod_ff <= 40'(mul_coef * mul_d);
         up_ff   <= mul_up;
      end
      if (cmd.gate) begin
         speech_ff <= speech;
         if (speech || hold_ff != '0) begin
            target_ff <= GAIN_ONE;
         end else if (rms_lt) begin
            target_ff <= '0;
         end else if (ratio_sat) begin
            target_ff <= RATIO_LIMIT;
         end else begin
            target_ff <= '0;
            rem_ff    <= diff;
            den_ff    <= den;
            quo_ff    <= '0;
         end
      end
      if (cmd.scale_start && comfort_on) begin
         scale_sel_ff <= 1'b1;
         quo_ff       <= scale_prod[SCALE_SHIFT +: 17];
      end
      if (cmd.div_step) begin
         rem_ff <= step_ge ? 25'(rem_sh - {1'b0, den_ff}) : rem_sh[24:0];
         quo_ff <= {quo_ff[15:0], step_ge};
      end
      if (cmd.ratio_take) begin
         target_ff <= (quo_ff > RATIO_LIMIT) ? RATIO_LIMIT : quo_ff;
      end
      if (cmd.load_out) begin
         if (bypass_ff) begin
            rsp_ff.gate_gain         <= GAIN_ONE;
            rsp_ff.noise_floor_level <= floor_ff;
            rsp_ff.speech_detected   <= 1'b0;
            rsp_ff.clamp_enable      <= 1'b0;
            rsp_ff.clamp_threshold   <= '0;
            rsp_ff.silence_scale     <= '0;
         end else begin
            rsp_ff.gate_gain         <= gain_ff;
            rsp_ff.noise_floor_level <= floor_ff;
            rsp_ff.speech_detected   <= speech_ff;
            rsp_ff.clamp_enable      <= (vad_ff < csr.vad_threshold)
                                        && (gain_ff <= Q_CLAMP_GATE);
            rsp_ff.clamp_threshold   <= clamp_thr;
            rsp_ff.silence_scale     <= scale_sel_ff ? quo_ff : '0;
         end
      end
   end

   assign rsp_data = rsp_ff;

   // gain never exceeds one
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE)
      else $error("smoothed gain above one");

   // an updated floor respects the minimum
   a_floor_min: assert property (@(posedge clock) disable iff (reset)
      (cmd.floor_upd && noise) |=> (floor_ff >= L_MIN_FLOOR))
      else $error("noise floor below minimum after update");

   // divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

/* sv/adaptive_noise_gate_controller.sv */
// adaptive_noise_gate_controller: top level with configuration registers
// instantiates ang_ctrl and ang_dp; depends on ang_pkg
//
// usage: one transaction on req_* per audio frame carries the frame's vad
// probability (q16) and post-filter rms (q0.24). each accepted transaction
// yields exactly one transaction on rsp_* with the smoothed gate gain, the
// learned noise floor, the speech flag, the clamp enable and threshold and
// the comfort-noise scale. csr_we writes register csr_index with csr_wdata
// (0 suppression level, 1 vad threshold, 2 comfort noise
// enable); other indexes are ignored. write only while no frame is in work.
// in bypass a frame goes from acceptance straight to its result; otherwise the
// 16-step serial division for the partial gain ratio, when needed, is the longest
// part of the work, the comfort-noise scale is a single reciprocal multiply, and
// the shared approach multiplier does each of the floor and gain updates as a
// multiply step followed by an update step.
// frames are taken one at a time.
// reset clears the floor, calibration and hold counts, sets the gain to one
// and restores the register defaults. the result register holds while
// rsp_ready is low; a new frame is accepted meanwhile but its result waits.
module adaptive_noise_gate_controller #(
   parameter int HOLD_FRAMES        = ang_pkg::HOLD_FRAMES_DEF,
   parameter int CALIBRATION_FRAMES = ang_pkg::CALIBRATION_FRAMES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ang_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ang_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [ang_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ang_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ang_pkg::*;

   csr_type csr_ff;
   cmd_type cmd;
   sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.suppression_level    <= SUPPRESSION_RST;
         csr_ff.vad_threshold        <= VAD_THR_RST;
         csr_ff.comfort_noise_enable <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SUPPRESSION: csr_ff.suppression_level    <= csr_wdata;
            CSR_VAD_THR:     csr_ff.vad_threshold        <= csr_wdata;
            CSR_COMFORT_EN:  csr_ff.comfort_noise_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ang_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ang_dp #(
      .HOLD_FRAMES        (HOLD_FRAMES),
      .CALIBRATION_FRAMES (CALIBRATION_FRAMES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr      (csr_ff),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
